// ----- hw/rtl/nor_flash_command_sequencer_top_macros.svh -----
// ----------------------------------------------------------------------------
// NOR flash command sequencer assertion macros
// Concurrent assertion helpers that compile away in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef NOR_FLASH_COMMAND_SEQUENCER_TOP_MACROS_SVH
`define NOR_FLASH_COMMAND_SEQUENCER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define NFCS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("nfcs assertion failed");
`define NFCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nfcs assertion failed");
`else
`define NFCS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define NFCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- hw/rtl/nfcs_pkg.sv -----
// ----------------------------------------------------------------------------
// NOR flash command sequencer package
// Shared types, command constants and bus width helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package nfcs_pkg;

  typedef enum logic [3:0] {
    MODE_RESET        = 4'd0,
    MODE_AUTOSEL      = 4'd1,
    MODE_QUERY        = 4'd2,
    MODE_CHIP_ERASE   = 4'd3,
    MODE_SECTOR_ERASE = 4'd4,
    MODE_BUF_START    = 4'd5,
    MODE_BUF_WORD     = 4'd6,
    MODE_CONFIRM      = 4'd7,
    MODE_TOGGLE_POLL  = 4'd8,
    MODE_VERIFY       = 4'd9
  } mode_t;

  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_OFFSET = 2'd1;
  localparam logic [1:0] CFG_PAGE   = 2'd2;

  localparam logic       KIND_WRITE = 1'b0;
  localparam logic       KIND_POLL  = 1'b1;

  localparam logic [1:0] POLL_BUSY = 2'd0;
  localparam logic [1:0] POLL_DONE = 2'd1;
  localparam logic [1:0] POLL_FAIL = 2'd2;

  localparam logic [31:0] ADDR_UNLOCK1 = 32'h0000_0555 << 1;
  localparam logic [31:0] ADDR_UNLOCK2 = 32'h0000_02AA << 1;
  localparam logic [31:0] ADDR_QUERY   = 32'h0000_0055 << 1;
  localparam logic [31:0] ADDR_ZERO    = 32'h0000_0000;

  localparam logic [7:0] CMD_UNLOCK1 = 8'hAA;
  localparam logic [7:0] CMD_UNLOCK2 = 8'h55;
  localparam logic [7:0] CMD_RESET   = 8'hF0;
  localparam logic [7:0] CMD_AUTOSEL = 8'h90;
  localparam logic [7:0] CMD_QUERY   = 8'h98;
  localparam logic [7:0] CMD_ERASE   = 8'h80;
  localparam logic [7:0] CMD_CHIP    = 8'h10;
  localparam logic [7:0] CMD_SECTOR  = 8'h30;
  localparam logic [7:0] CMD_BUFFER  = 8'h25;
  localparam logic [7:0] CMD_CONFIRM = 8'h29;

  localparam logic [31:0] DQ6 = 32'h0000_0040;
  localparam logic [31:0] DQ5 = 32'h0000_0020;
  localparam logic [31:0] DQ1 = 32'h0000_0002;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [1:0]  width_code;
    logic [31:0] address_offset;
    logic [3:0]  page_log2;
  } cfg_t;

  typedef struct packed {
    mode_t       mode;
    logic [31:0] address;
    logic [31:0] data;
    logic [1:0]  status;
  } desc_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] bus_address;
    logic [31:0] bus_data;
    logic [1:0]  poll_status;
    logic        last;
  } result_t;

  function automatic logic [1:0] bytes_log2(input logic [1:0] width_code);
    return (width_code >= 2'd2) ? 2'd2 : width_code;
  endfunction

  function automatic logic [31:0] bus_mask(input logic [1:0] width_code);
    logic [31:0] m;
    case (bytes_log2(width_code))
      2'd0:    m = 32'h0000_00FF;
      2'd1:    m = 32'h0000_FFFF;
      default: m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/nfcs_if.sv -----
// ----------------------------------------------------------------------------
// NOR flash command sequencer channel interfaces
// Valid/ready channels for command items, results and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface nfcs_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  mode;
  logic [31:0] address;
  logic [31:0] data;
  modport source (output valid, mode, address, data, input ready);
  modport sink   (input valid, mode, address, data, output ready);
endinterface

interface nfcs_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] bus_address;
  logic [31:0] bus_data;
  logic [1:0]  poll_status;
  logic        last;
  modport source (output valid, kind, bus_address, bus_data, poll_status, last,
                  input ready);
  modport sink   (input valid, kind, bus_address, bus_data, poll_status, last,
                  output ready);
endinterface

interface nfcs_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] wdata;
  modport source (output valid, index, wdata, input ready);
  modport sink   (input valid, index, wdata, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/nfcs_front.sv -----
// ----------------------------------------------------------------------------
// NOR flash command sequencer front end
// Accepts command items, evaluates polls and queues work for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module nfcs_front import nfcs_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire cfg_t  cfg,
  nfcs_in_if.sink    in_ch,
  input  wire logic  q_full,
  output logic       q_push,
  output desc_t      q_desc
);

  typedef enum logic [3:0] {
    TG_IDLE    = 4'b0001,
    TG_HELD    = 4'b0010,
    TG_RECHK1  = 4'b0100,
    TG_RECHK2  = 4'b1000
  } toggle_state_t;

  toggle_state_t tg_state_r, tg_state_nxt;
  logic [31:0]   prev_status_r, prev_status_nxt;
  logic          recheck_r, recheck_nxt;
  logic [31:0]   last_word_r, last_word_nxt;

  logic          accept;
  mode_t         mode;
  logic [31:0]   mask;
  logic [31:0]   st;
  logic          dq6_changed;
  logic [1:0]    toggle_res;
  logic [1:0]    verify_res;
  logic [15:0]   page_bytes;
  logic [15:0]   page_words;
  logic [7:0]    word_count;
  logic          known;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign mode        = mode_t'(in_ch.mode);
  assign mask        = bus_mask(cfg.width_code);
  assign st          = in_ch.data & mask;
  assign dq6_changed = ((st ^ prev_status_r) & DQ6) != 32'd0;
  assign page_bytes  = 16'd1 << cfg.page_log2;
  assign page_words  = page_bytes >> bytes_log2(cfg.width_code);
  assign word_count  = 8'(page_words - 16'd1);
  assign known       = in_ch.mode <= 4'(MODE_VERIFY);

  always_comb begin
    tg_state_nxt    = tg_state_r;
    prev_status_nxt = prev_status_r;
    toggle_res      = POLL_BUSY;
    case (tg_state_r)
      TG_IDLE: begin
        prev_status_nxt = st;
        tg_state_nxt    = TG_HELD;
      end
      TG_HELD: begin
        prev_status_nxt = st;
        if (!dq6_changed) begin
          toggle_res   = POLL_DONE;
          tg_state_nxt = TG_IDLE;
        end else if ((st & DQ5) != 32'd0) begin
          tg_state_nxt = TG_RECHK1;
        end
      end
      TG_RECHK1: begin
        prev_status_nxt = st;
        tg_state_nxt    = TG_RECHK2;
      end
      default: begin
        prev_status_nxt = st;
        toggle_res      = dq6_changed ? POLL_FAIL : POLL_DONE;
        tg_state_nxt    = TG_IDLE;
      end
    endcase
  end

  always_comb begin
    recheck_nxt = recheck_r;
    verify_res  = POLL_BUSY;
    if (st == last_word_r) begin
      verify_res  = POLL_DONE;
      recheck_nxt = 1'b0;
    end else if (recheck_r) begin
      verify_res  = POLL_FAIL;
      recheck_nxt = 1'b0;
    end else if ((st & (DQ5 | DQ1)) != 32'd0) begin
      recheck_nxt = 1'b1;
    end
  end

  assign last_word_nxt = st;

  always_comb begin
    q_desc.mode    = mode;
    q_desc.address = in_ch.address;
    q_desc.data    = st;
    q_desc.status  = POLL_BUSY;
    case (mode)
      MODE_BUF_START:   q_desc.data   = {24'd0, word_count};
      MODE_TOGGLE_POLL: q_desc.status = toggle_res;
      MODE_VERIFY:      q_desc.status = verify_res;
      default:          q_desc.data   = st;
    endcase
  end

  assign q_push = accept && known;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tg_state_r    <= TG_IDLE;
      prev_status_r <= 32'd0;
      recheck_r     <= 1'b0;
      last_word_r   <= 32'd0;
    end else if (accept) begin
      case (mode)
        MODE_TOGGLE_POLL: begin
          tg_state_r    <= tg_state_nxt;
          prev_status_r <= prev_status_nxt;
        end
        MODE_VERIFY:   recheck_r   <= recheck_nxt;
        MODE_BUF_WORD: last_word_r <= last_word_nxt;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/nfcs_queue.sv -----
// ----------------------------------------------------------------------------
// NOR flash command sequencer work queue
// Two-entry FIFO of classified commands between front and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module nfcs_queue import nfcs_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire desc_t push_desc,
  output logic       full,
  input  wire logic  pop,
  output desc_t      head,
  output logic       empty
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  desc_t              entry_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               do_push;
  logic               do_pop;

  assign full    = count_r == CNT_W'(QUEUE_DEPTH);
  assign empty   = count_r == '0;
  assign head    = entry_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_desc;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/nfcs_back.sv -----
// ----------------------------------------------------------------------------
// NOR flash command sequencer back end
// Expands queued commands into bus write cycles and poll results.
// ----------------------------------------------------------------------------
`default_nettype none

module nfcs_back import nfcs_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire cfg_t  cfg,
  input  wire desc_t head,
  input  wire logic  empty,
  output logic       pop,
  nfcs_out_if.source out_ch
);

  logic [2:0]  step_r, step_nxt;
  logic        out_valid_r, out_valid_nxt;
  result_t     out_r;
  result_t     cyc;
  logic [2:0]  n_steps;
  logic        advance;
  logic        is_last;
  logic [31:0] raw_addr;
  logic [7:0]  raw_cmd;

  function automatic logic [2:0] step_count(input mode_t m);
    logic [2:0] n;
    case (m)
      MODE_RESET, MODE_AUTOSEL:          n = 3'd3;
      MODE_CHIP_ERASE, MODE_SECTOR_ERASE: n = 3'd6;
      MODE_BUF_START:                    n = 3'd4;
      default:                           n = 3'd1;
    endcase
    return n;
  endfunction

  assign n_steps = step_count(head.mode);
  assign is_last = step_r == (n_steps - 3'd1);
  assign advance = !out_valid_r || out_ch.ready;

  always_comb begin
    raw_addr = ADDR_UNLOCK1;
    raw_cmd  = CMD_UNLOCK1;
    case (step_r)
      3'd0: begin
        raw_addr = ADDR_UNLOCK1;
        raw_cmd  = CMD_UNLOCK1;
      end
      3'd1, 3'd4: begin
        raw_addr = ADDR_UNLOCK2;
        raw_cmd  = CMD_UNLOCK2;
      end
      3'd3: begin
        raw_addr = ADDR_UNLOCK1;
        raw_cmd  = CMD_UNLOCK1;
      end
      default: begin
        raw_addr = ADDR_UNLOCK1;
        raw_cmd  = CMD_ERASE;
      end
    endcase
  end

  always_comb begin
    cyc.kind        = KIND_WRITE;
    cyc.bus_address = raw_addr;
    cyc.bus_data    = {24'd0, raw_cmd};
    cyc.poll_status = POLL_BUSY;
    cyc.last        = is_last;
    case (head.mode)
      MODE_RESET: begin
        if (is_last) begin
          cyc.bus_address = ADDR_ZERO;
          cyc.bus_data    = {24'd0, CMD_RESET};
        end
      end
      MODE_AUTOSEL: begin
        if (is_last) begin
          cyc.bus_address = ADDR_UNLOCK1;
          cyc.bus_data    = {24'd0, CMD_AUTOSEL};
        end
      end
      MODE_QUERY: begin
        cyc.bus_address = ADDR_QUERY;
        cyc.bus_data    = {24'd0, CMD_QUERY};
      end
      MODE_CHIP_ERASE: begin
        if (is_last) begin
          cyc.bus_address = ADDR_UNLOCK1;
          cyc.bus_data    = {24'd0, CMD_CHIP};
        end
      end
      MODE_SECTOR_ERASE: begin
        if (is_last) begin
          cyc.bus_address = head.address;
          cyc.bus_data    = {24'd0, CMD_SECTOR};
        end
      end
      MODE_BUF_START: begin
        if (step_r == 3'd2) begin
          cyc.bus_address = head.address;
          cyc.bus_data    = {24'd0, CMD_BUFFER};
        end else if (is_last) begin
          cyc.bus_address = head.address;
          cyc.bus_data    = head.data;
        end
      end
      MODE_BUF_WORD: begin
        cyc.bus_address = head.address;
        cyc.bus_data    = head.data;
      end
      MODE_CONFIRM: begin
        cyc.bus_address = head.address;
        cyc.bus_data    = {24'd0, CMD_CONFIRM};
      end
      default: begin
        cyc.kind        = KIND_POLL;
        cyc.bus_address = ADDR_ZERO;
        cyc.bus_data    = 32'd0;
        cyc.poll_status = head.status;
      end
    endcase
    if (cyc.kind == KIND_WRITE) begin
      cyc.bus_address = cyc.bus_address + cfg.address_offset;
      cyc.bus_data    = cyc.bus_data & bus_mask(cfg.width_code);
    end
  end

  always_comb begin
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    pop           = 1'b0;
    if (advance) begin
      out_valid_nxt = !empty;
      if (!empty) begin
        if (is_last) begin
          step_nxt = 3'd0;
          pop      = 1'b1;
        end else begin
          step_nxt = step_r + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && !empty) begin
      out_r <= cyc;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.kind        = out_r.kind;
  assign out_ch.bus_address = out_r.bus_address;
  assign out_ch.bus_data    = out_r.bus_data;
  assign out_ch.poll_status = out_r.poll_status;
  assign out_ch.last        = out_r.last;

endmodule

`default_nettype wire

// ----- hw/rtl/nor_flash_command_sequencer_top.sv -----
// ----------------------------------------------------------------------------
// NOR flash command sequencer
// Host side command and status poll sequencer for AMD-style NOR flash.
// ----------------------------------------------------------------------------
// Usage:
// Items arrive on in_ch and each names one mode with an address and data
// word. Command modes produce their bus write cycles on out_ch, one result
// per transfer, with last set on the final cycle. Poll modes produce one
// poll status result. Unknown modes are taken and produce nothing.
// Registers are written on cfg_ch, which is always ready; write them only
// while no item is in flight.
// The first result of an item is registered in the queue and then in the
// output register. The back end emits one result per cycle while the
// receiver is ready, so an item occupies it for its one to six results,
// set by its number of bus write cycles. A two-entry queue lets the front
// end keep taking items while results wait. When the receiver stalls, the
// current result holds and the queue fills; in_ch.ready drops once it is full.
// Reset clears the queue, the output valid flag and the poll state and loads
// the register defaults: 16-bit bus, zero offset, 32-byte page.
// ----------------------------------------------------------------------------
`default_nettype none

`include "nor_flash_command_sequencer_top_macros.svh"

module nor_flash_command_sequencer_top import nfcs_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  nfcs_in_if.sink    in_ch,
  nfcs_out_if.source out_ch,
  nfcs_cfg_if.sink   cfg_ch
);

  cfg_t  cfg_r;
  logic  q_full;
  logic  q_empty;
  logic  q_push;
  logic  q_pop;
  desc_t q_push_desc;
  desc_t q_head;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.width_code     <= 2'd1;
      cfg_r.address_offset <= 32'd0;
      cfg_r.page_log2      <= 4'd5;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        CFG_WIDTH:  cfg_r.width_code     <= cfg_ch.wdata[1:0];
        CFG_OFFSET: cfg_r.address_offset <= cfg_ch.wdata;
        CFG_PAGE:   cfg_r.page_log2      <= cfg_ch.wdata[3:0];
        default: ;
      endcase
    end
  end

  nfcs_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_desc (q_push_desc)
  );

  nfcs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_desc (q_push_desc),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  nfcs_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .head   (q_head),
    .empty  (q_empty),
    .pop    (q_pop),
    .out_ch (out_ch)
  );

  `NFCS_ASSERT_IMPL(a_full_blocks_input, clk, rst_n, q_full, !in_ch.ready)
  `NFCS_ASSERT_NEXT(a_full_holds, clk, rst_n, q_full && !q_pop, q_full)
  `NFCS_ASSERT_IMPL(a_poll_no_bus, clk, rst_n, out_ch.valid && out_ch.kind, out_ch.bus_address == 32'd0 && out_ch.bus_data == 32'd0 && out_ch.last)
  `NFCS_ASSERT_IMPL(a_write_no_status, clk, rst_n, out_ch.valid && !out_ch.kind, out_ch.poll_status == POLL_BUSY)

endmodule

`default_nettype wire

// ----- test/tb_nor_flash_command_sequencer_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// NOR flash command sequencer testbench
// Drives command and status poll items into the sequencer under several
// register settings and checks every bus write cycle and poll status against
// a cycle-free model of the command set, with random gaps on both channels.
// ----------------------------------------------------------------------------

module tb_nor_flash_command_sequencer_top;
  import nfcs_pkg::*;

  typedef struct packed {
    logic [3:0]  mode;
    logic [31:0] address;
    logic [31:0] data;
  } cmd_item_t;

  typedef enum logic [1:0] {
    TOG_NONE    = 2'd0,
    TOG_HELD    = 2'd1,
    TOG_REREAD1 = 2'd2,
    TOG_REREAD2 = 2'd3
  } toggle_phase_t;

  logic clk;
  logic rst_n;

  nfcs_in_if  in_ch();
  nfcs_out_if out_ch();
  nfcs_cfg_if cfg_ch();

  nor_flash_command_sequencer_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  cmd_item_t     pending_cmds[$];
  cmd_item_t     on_bus;
  result_t       cycles_owed[$];
  result_t       cycle_batch[$];
  int            commands_queued;
  int            failures;
  bit            idling_on;
  bit            hold_request;
  int            hold_left;

  logic [1:0]    bus_width_code;
  logic [31:0]   bus_offset;
  logic [3:0]    page_bits;
  logic [31:0]   toggle_prev;
  toggle_phase_t toggle_phase;
  logic          verify_owed;
  logic [31:0]   last_word;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic logic [31:0] width_mask();
    logic [1:0] blog;
    blog = (bus_width_code >= 2'd2) ? 2'd2 : bus_width_code;
    if (blog == 2'd0) return 32'h0000_00FF;
    if (blog == 2'd1) return 32'h0000_FFFF;
    return 32'hFFFF_FFFF;
  endfunction

  function automatic void add_write(input logic [31:0] addr, input logic [31:0] data);
    result_t r;
    r.kind        = KIND_WRITE;
    r.bus_address = addr + bus_offset;
    r.bus_data    = data & width_mask();
    r.poll_status = '0;
    r.last        = 1'b0;
    cycle_batch.push_back(r);
  endfunction

  function automatic void add_unlock();
    add_write(ADDR_UNLOCK1, {24'd0, CMD_UNLOCK1});
    add_write(ADDR_UNLOCK2, {24'd0, CMD_UNLOCK2});
  endfunction

  function automatic logic [1:0] toggle_read(input logic [31:0] st);
    logic [1:0] status;
    status = POLL_BUSY;
    case (toggle_phase)
      TOG_NONE: begin
        toggle_prev  = st;
        toggle_phase = TOG_HELD;
      end
      TOG_HELD: begin
        if (((st ^ toggle_prev) & DQ6) == 32'd0) begin
          status       = POLL_DONE;
          toggle_phase = TOG_NONE;
        end else if ((st & DQ5) != 32'd0) begin
          toggle_phase = TOG_REREAD1;
        end
        toggle_prev = st;
      end
      TOG_REREAD1: begin
        toggle_prev  = st;
        toggle_phase = TOG_REREAD2;
      end
      default: begin
        status       = (((st ^ toggle_prev) & DQ6) != 32'd0) ? POLL_FAIL : POLL_DONE;
        toggle_prev  = st;
        toggle_phase = TOG_NONE;
      end
    endcase
    return status;
  endfunction

  function automatic logic [1:0] verify_read(input logic [31:0] st);
    if (st == last_word) begin
      verify_owed = 1'b0;
      return POLL_DONE;
    end
    if (verify_owed) begin
      verify_owed = 1'b0;
      return POLL_FAIL;
    end
    if ((st & (DQ5 | DQ1)) != 32'd0) verify_owed = 1'b1;
    return POLL_BUSY;
  endfunction

  function automatic void run_command(input cmd_item_t it);
    logic [31:0] mask;
    logic [31:0] page_words;
    logic [1:0]  blog;
    result_t     r;
    mask = width_mask();
    blog = (bus_width_code >= 2'd2) ? 2'd2 : bus_width_code;
    cycle_batch.delete();
    r.kind        = KIND_POLL;
    r.bus_address = '0;
    r.bus_data    = '0;
    r.poll_status = POLL_BUSY;
    r.last        = 1'b0;
    case (it.mode)
      MODE_RESET: begin
        add_unlock();
        add_write(ADDR_ZERO, {24'd0, CMD_RESET});
      end
      MODE_AUTOSEL: begin
        add_unlock();
        add_write(ADDR_UNLOCK1, {24'd0, CMD_AUTOSEL});
      end
      MODE_QUERY: add_write(ADDR_QUERY, {24'd0, CMD_QUERY});
      MODE_CHIP_ERASE, MODE_SECTOR_ERASE: begin
        add_unlock();
        add_write(ADDR_UNLOCK1, {24'd0, CMD_ERASE});
        add_unlock();
        if (it.mode == MODE_CHIP_ERASE) add_write(ADDR_UNLOCK1, {24'd0, CMD_CHIP});
        else add_write(it.address, {24'd0, CMD_SECTOR});
      end
      MODE_BUF_START: begin
        page_words = ((32'd1 << page_bits) >> blog) - 32'd1;
        add_unlock();
        add_write(it.address, {24'd0, CMD_BUFFER});
        add_write(it.address, {24'd0, page_words[7:0]});
      end
      MODE_BUF_WORD: begin
        last_word = it.data & mask;
        add_write(it.address, it.data);
      end
      MODE_CONFIRM: add_write(it.address, {24'd0, CMD_CONFIRM});
      MODE_TOGGLE_POLL: begin
        r.poll_status = toggle_read(it.data & mask);
        cycle_batch.push_back(r);
      end
      MODE_VERIFY: begin
        r.poll_status = verify_read(it.data & mask);
        cycle_batch.push_back(r);
      end
      default: ;
    endcase
    if (cycle_batch.size() != 0) begin
      r = cycle_batch.pop_back();
      r.last = 1'b1;
      cycle_batch.push_back(r);
      foreach (cycle_batch[i]) cycles_owed.push_back(cycle_batch[i]);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) run_command(on_bus);
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_cmds.size() != 0 && (!idling_on || $urandom_range(99) >= 14)) begin
          on_bus = pending_cmds.pop_front();
          in_ch.valid   <= 1'b1;
          in_ch.mode    <= on_bus.mode;
          in_ch.address <= on_bus.address;
          in_ch.data    <= on_bus.data;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_request && hold_left == 0) begin
      hold_left    <= 80;
      hold_request <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (cycles_owed.size() == 0) begin
          $error("result transfer with nothing owed: kind %0d address %h data %h",
                 out_ch.kind, out_ch.bus_address, out_ch.bus_data);
          failures++;
        end else begin
          want = cycles_owed.pop_front();
          if (out_ch.kind !== want.kind) begin
            $error("kind: expected %0d, actual %0d", want.kind, out_ch.kind);
            failures++;
          end
          if (out_ch.bus_address !== want.bus_address) begin
            $error("bus_address: expected %h, actual %h", want.bus_address,
                   out_ch.bus_address);
            failures++;
          end
          if (out_ch.bus_data !== want.bus_data) begin
            $error("bus_data: expected %h, actual %h", want.bus_data, out_ch.bus_data);
            failures++;
          end
          if (out_ch.poll_status !== want.poll_status) begin
            $error("poll_status: expected %0d, actual %0d", want.poll_status,
                   out_ch.poll_status);
            failures++;
          end
          if (out_ch.last !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, out_ch.last);
            failures++;
          end
        end
      end
      if (hold_left != 0) out_ch.ready <= 1'b0;
      else out_ch.ready <= !idling_on || $urandom_range(99) >= 14;
    end
  end

  task automatic queue_cmd(input logic [3:0] mode, input logic [31:0] addr,
                           input logic [31:0] data);
    cmd_item_t it;
    it.mode    = mode;
    it.address = addr;
    it.data    = data;
    pending_cmds.push_back(it);
    if (mode <= MODE_VERIFY) commands_queued++;
  endtask

  task automatic cfg_write(input logic [1:0] index, input logic [31:0] value);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= index;
    cfg_ch.wdata <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (index)
      CFG_WIDTH:  bus_width_code = value[1:0];
      CFG_OFFSET: bus_offset     = value;
      CFG_PAGE:   page_bits      = value[3:0];
      default: ;
    endcase
  endtask

  task automatic wait_quiet();
    int n;
    n = 0;
    while ((pending_cmds.size() != 0 || in_ch.valid || cycles_owed.size() != 0)
           && n < 20000) begin
      @(posedge clk);
      n++;
    end
    if (cycles_owed.size() != 0) begin
      $error("%0d results never arrived", cycles_owed.size());
      failures++;
      cycles_owed.delete();
    end
    repeat (12) @(posedge clk);
  endtask

  task automatic queue_program();
    logic [31:0] page;
    logic [31:0] word;
    int          n;
    page = $urandom;
    word = $urandom;
    queue_cmd(MODE_BUF_START, page, $urandom);
    n = $urandom_range(1, 4);
    for (int i = 0; i < n; i++) begin
      word = $urandom;
      queue_cmd(MODE_BUF_WORD, page + i * 4, word);
    end
    queue_cmd(MODE_CONFIRM, page, $urandom);
    n = $urandom_range(1, 3);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(3))
        0: queue_cmd(MODE_VERIFY, $urandom, word);
        1: queue_cmd(MODE_VERIFY, $urandom, word ^ ($urandom_range(1) ? DQ5 : DQ1));
        2: queue_cmd(MODE_VERIFY, $urandom, $urandom);
        default: queue_cmd(MODE_VERIFY, $urandom, word ^ 32'hFFFF_0000);
      endcase
    end
  endtask

  task automatic queue_erase();
    logic [31:0] st;
    int          n;
    queue_cmd($urandom_range(1) ? MODE_CHIP_ERASE : MODE_SECTOR_ERASE, $urandom, $urandom);
    st = $urandom;
    n  = $urandom_range(2, 6);
    for (int i = 0; i < n; i++) begin
      st = st ^ ($urandom & 32'hFFFF_FF9F);
      if ($urandom_range(9) < 7) st = st ^ DQ6;
      if ($urandom_range(9) < 3) st = st | DQ5;
      else st = st & ~DQ5;
      queue_cmd(MODE_TOGGLE_POLL, $urandom, st);
    end
  endtask

  task automatic queue_random(input int target);
    commands_queued = 0;
    while (commands_queued < target) begin
      case ($urandom_range(19))
        0, 1, 2, 3, 4, 5, 6: queue_program();
        7, 8, 9, 10, 11, 12, 13: queue_erase();
        14, 15, 16: begin
          case ($urandom_range(2))
            0: queue_cmd(MODE_RESET, $urandom, $urandom);
            1: queue_cmd(MODE_AUTOSEL, $urandom, $urandom);
            default: queue_cmd(MODE_QUERY, $urandom, $urandom);
          endcase
        end
        default: queue_cmd(4'($urandom_range(15)), $urandom, $urandom);
      endcase
    end
  endtask

  task automatic run_phase(input logic [1:0] width, input logic [31:0] offset,
                           input logic [3:0] page, input bit hold, input bit gaps);
    cfg_write(CFG_WIDTH, {30'd0, width});
    cfg_write(CFG_OFFSET, offset);
    cfg_write(CFG_PAGE, {28'd0, page});
    idling_on = gaps;
    if (hold) hold_request <= 1'b1;
    queue_random(56);
    wait_quiet();
  endtask

  initial begin
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.mode     = '0;
    in_ch.address  = '0;
    in_ch.data     = '0;
    out_ch.ready   = 1'b0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.index   = '0;
    cfg_ch.wdata   = '0;
    failures       = 0;
    idling_on      = 1'b1;
    hold_request   = 1'b0;
    bus_width_code = 2'd1;
    bus_offset     = 32'd0;
    page_bits      = 4'd5;
    toggle_prev    = 32'd0;
    toggle_phase   = TOG_NONE;
    verify_owed    = 1'b0;
    last_word      = 32'd0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    queue_cmd(MODE_RESET, 32'd0, 32'd0);
    queue_cmd(MODE_AUTOSEL, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_cmd(MODE_QUERY, 32'd0, 32'd0);
    queue_cmd(MODE_CHIP_ERASE, 32'd0, 32'd0);
    queue_cmd(MODE_SECTOR_ERASE, 32'd0, 32'd0);
    queue_cmd(MODE_SECTOR_ERASE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_cmd(MODE_BUF_START, 32'h0001_0000, 32'd0);
    queue_cmd(MODE_BUF_WORD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_cmd(4'd10, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_cmd(MODE_CONFIRM, 32'h0001_0000, 32'd0);
    queue_cmd(4'd15, 32'd0, 32'd0);
    queue_cmd(MODE_TOGGLE_POLL, 32'd0, 32'h0000_0000);
    queue_cmd(MODE_TOGGLE_POLL, 32'd0, 32'h0000_0000);
    queue_cmd(MODE_TOGGLE_POLL, 32'd0, 32'h0000_0040);
    queue_cmd(MODE_TOGGLE_POLL, 32'd0, 32'h0000_0000);
    queue_cmd(MODE_TOGGLE_POLL, 32'd0, 32'h0000_0060);
    queue_cmd(MODE_TOGGLE_POLL, 32'd0, 32'h0000_0020);
    queue_cmd(MODE_TOGGLE_POLL, 32'd0, 32'hFFFF_0060);
    queue_cmd(MODE_VERIFY, 32'd0, 32'h0000_FFFF);
    queue_cmd(MODE_VERIFY, 32'd0, 32'h0000_0022);
    queue_cmd(MODE_VERIFY, 32'd0, 32'h0000_0000);
    queue_cmd(MODE_VERIFY, 32'd0, 32'h0000_0001);
    queue_cmd(MODE_VERIFY, 32'd0, 32'hABCD_FFFF);
    wait_quiet();

    run_phase(2'd0, 32'd0, 4'd1, 1'b0, 1'b1);
    run_phase(2'd2, 32'hFFFF_FFFF, 4'd9, 1'b1, 1'b1);
    run_phase(2'd3, $urandom, 4'd0, 1'b0, 1'b0);
    run_phase(2'd1, $urandom, 4'd15, 1'b0, 1'b1);
    run_phase(2'd0, 32'hFFFF_FFF0, 4'($urandom_range(1, 9)), 1'b0, 1'b1);
    run_phase(2'd2, $urandom, 4'($urandom_range(1, 9)), 1'b0, 1'b1);

    if (failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/nfcs_pkg.sv
hw/rtl/nfcs_if.sv
hw/rtl/nfcs_front.sv
hw/rtl/nfcs_queue.sv
hw/rtl/nfcs_back.sv
hw/rtl/nor_flash_command_sequencer_top.sv
test/tb_nor_flash_command_sequencer_top.sv
